FILE: rtl/erp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erp_pkg: shared constants and types for the pivot rotation block
// Widths, CORDIC arctangent table and the fixed conversion constants.
// ----------------------------------------------------------------------------
package erp_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int ANGLE_WIDTH     = 26;
   localparam int CORDIC_STEPS    = 30;
   localparam int STEP_WIDTH      = 5;
   // Q2.30 values plus headroom
   localparam int TRIG_WIDTH      = 33;
   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [34:0] DEG2RAD = 35'd19190098069;

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;

   typedef struct packed {
      trig_type x;
      trig_type y;
      trig_type z;
   } cordic_type;

   function automatic trig_type atan_lookup(input logic [STEP_WIDTH-1:0] idx);
      trig_type v;
      case (idx)
         5'd0:  v = 33'sd843314856;
         5'd1:  v = 33'sd497837829;
         5'd2:  v = 33'sd263043836;
         5'd3:  v = 33'sd133525158;
         5'd4:  v = 33'sd67021686;
         5'd5:  v = 33'sd33543515;
         5'd6:  v = 33'sd16775850;
         5'd7:  v = 33'sd8388437;
         5'd8:  v = 33'sd4194282;
         5'd9:  v = 33'sd2097149;
         5'd10: v = 33'sd1048575;
         5'd11: v = 33'sd524287;
         5'd12: v = 33'sd262143;
         5'd13: v = 33'sd131071;
         5'd14: v = 33'sd65535;
         5'd15: v = 33'sd32767;
         5'd16: v = 33'sd16383;
         5'd17: v = 33'sd8191;
         5'd18: v = 33'sd4095;
         5'd19: v = 33'sd2047;
         5'd20: v = 33'sd1023;
         5'd21: v = 33'sd511;
         5'd22: v = 33'sd255;
         5'd23: v = 33'sd127;
         5'd24: v = 33'sd63;
         5'd25: v = 33'sd31;
         5'd26: v = 33'sd15;
         5'd27: v = 33'sd8;
         5'd28: v = 33'sd4;
         5'd29: v = 33'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/euler_rotate_point_about_pivot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_rotate_point_about_pivot: rotate a point about a pivot, Z*Y*X order
// Angle reduction, a 30-cell CORDIC chain, matrix build and rotation.
// ----------------------------------------------------------------------------
// Pipeline: 3 angle-reduce stages, 30 CORDIC cells and 5 matrix/rotate stages,
// all registered. Throughput: one item per cycle, busy is always low.
// The receiver cannot stall; every result is shown for one cycle.
// Reset clears the valid pipe only; payload stages run freely.
module euler_rotate_point_about_pivot #(
   parameter int COORD_WIDTH = erp_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = erp_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_pivot_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_pivot_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_pivot_z,
   input  wire logic signed [erp_pkg::ANGLE_WIDTH-1:0] req_pitch_deg,
   input  wire logic signed [erp_pkg::ANGLE_WIDTH-1:0] req_yaw_deg,
   input  wire logic signed [erp_pkg::ANGLE_WIDTH-1:0] req_roll_deg,
   output      logic                          rsp_valid,
   output      logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   output      logic signed [COORD_WIDTH-1:0] rsp_rotated_y,
   output      logic signed [COORD_WIDTH-1:0] rsp_rotated_z,
   output      logic                          rsp_saturated
);
   localparam int AW    = erp_pkg::ANGLE_WIDTH;
   localparam int TW    = erp_pkg::TRIG_WIDTH;
   localparam int NS    = erp_pkg::CORDIC_STEPS;
   localparam int LAT   = 3 + NS + 5;
   localparam int DW    = COORD_WIDTH + 1;
   localparam int PW    = DW + 31;
   localparam int AccW  = PW + 2;
   localparam int SH    = 10 + FRAC_BITS;
   localparam logic signed [AW+1:0] FULL    = (AW+2)'(360) <<< FRAC_BITS;
   localparam logic signed [AW+1:0] HALF    = (AW+2)'(180) <<< FRAC_BITS;
   localparam logic signed [AW+1:0] QUARTER = (AW+2)'(90) <<< FRAC_BITS;
   localparam int MW = AW + 36;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DW-1:0] diff_type;

   assign busy = 1'b0;

   // ---------------- valid pipe and coordinate delay line ----------------
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   localparam int DLY = 3 + NS + 2;  // d and pivot needed at rotate stage
   diff_type  d_ff [DLY][3];
   coord_type q_ff [DLY+2][3];
   always_ff @(posedge clock) begin
      d_ff[0][0] <= DW'(req_point_x) - DW'(req_pivot_x);
      d_ff[0][1] <= DW'(req_point_y) - DW'(req_pivot_y);
      d_ff[0][2] <= DW'(req_point_z) - DW'(req_pivot_z);
      q_ff[0][0] <= req_pivot_x;
      q_ff[0][1] <= req_pivot_y;
      q_ff[0][2] <= req_pivot_z;
      for (int s = 1; s < DLY; s++) d_ff[s] <= d_ff[s-1];
      for (int s = 1; s < DLY + 2; s++) q_ff[s] <= q_ff[s-1];
   end

   // ---------------- angle reduction: 3 stages ----------------
   logic signed [AW+1:0] r1_ff [3];
   logic signed [AW+1:0] r2_ff [3];
   logic                 n2_ff [3];
   logic                 n3_ff [3];
   logic signed [TW-1:0] rad3_ff [3];
   logic signed [AW-1:0] ang [3];
   logic signed [AW+1:0] r1_in [3];
   logic signed [AW+1:0] r2_in [3];
   logic                 n2_in [3];
   logic signed [TW-1:0] rad3_in [3];

   assign ang[0] = req_pitch_deg;
   assign ang[1] = req_yaw_deg;
   assign ang[2] = req_roll_deg;

   always_comb begin
      logic signed [AW+1:0] a, t;
      logic [AW+1:0] mag;
      logic [MW-1:0] prod;
      for (int k = 0; k < 3; k++) begin
         a = (AW+2)'(ang[k]);
         // user must keep input in +-360 (unchecked); one add/sub maps it to [0,360)
         t = (a < 0) ? a + FULL : a;
         if (t >= FULL) t = t - FULL;
         r1_in[k] = (t >= HALF) ? t - FULL : t;
         t = r1_ff[k];
         n2_in[k] = 1'b0;
         if (t > QUARTER) begin
            t = (QUARTER <<< 1) - t;
            n2_in[k] = 1'b1;
         end else if (t < -QUARTER) begin
            t = -(QUARTER <<< 1) - t;
            n2_in[k] = 1'b1;
         end
         r2_in[k] = t;
         t = r2_ff[k];
         mag = (t < 0) ? (AW+2)'(-t) : (AW+2)'(t);
         prod = (MW'(mag) * MW'(erp_pkg::DEG2RAD) + (MW'(1) << (SH - 1))) >> SH;
         rad3_in[k] = (t < 0) ? -TW'(prod) : TW'(prod);
      end
   end

   always_ff @(posedge clock) begin
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
      n2_ff   <= n2_in;
      rad3_ff <= rad3_in;
      n3_ff   <= n2_ff;
   end

   // ---------------- CORDIC chain ----------------
   erp_pkg::cordic_type chain [NS+1][3];
   logic neg_ff [NS][3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         chain[0][k].x = erp_pkg::CORDIC_GAIN;
         chain[0][k].y = '0;
         chain[0][k].z = rad3_ff[k];
      end
   end
   always_ff @(posedge clock) begin
      neg_ff[0] <= n3_ff;
      for (int s = 1; s < NS; s++) neg_ff[s] <= neg_ff[s-1];
   end

   for (genvar g = 0; g < NS; g++) begin : g_cell
      erp_cordic_cell #(.STEP(g)) u_cell (
         .clock   (clock),
         .lane_in (chain[g]),
         .lane_out(chain[g+1])
      );
   end

   // sin/cos for pitch(0), yaw(1), roll(2)
   logic signed [TW-1:0] sn [3];
   logic signed [TW-1:0] cs [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sn[k] = chain[NS][k].y;
         cs[k] = neg_ff[NS-1][k] ? -chain[NS][k].x : chain[NS][k].x;
      end
   end

   function automatic logic signed [TW-1:0] mul30(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
      logic signed [2*TW-1:0] p;
      p = (2*TW)'(a) * (2*TW)'(b) + ((2*TW)'(1) <<< 29);
      return TW'(p >>> 30);
   endfunction

   // ---------------- matrix stage A: two-factor products ----------------
   logic signed [TW-1:0] spsy_ff, cpsy_ff, cycr_ff, cpsr_ff, spsr_ff, cysr_ff;
   logic signed [TW-1:0] cpcr_ff, spcr_ff, nsy_ff, spcy_ff, cpcy_ff, cr_ff, sr_ff;
   always_ff @(posedge clock) begin
      spsy_ff <= mul30(sn[0], sn[1]);
      cpsy_ff <= mul30(cs[0], sn[1]);
      cycr_ff <= mul30(cs[1], cs[2]);
      cpsr_ff <= mul30(cs[0], sn[2]);
      spsr_ff <= mul30(sn[0], sn[2]);
      cysr_ff <= mul30(cs[1], sn[2]);
      cpcr_ff <= mul30(cs[0], cs[2]);
      spcr_ff <= mul30(sn[0], cs[2]);
      nsy_ff  <= -sn[1];
      spcy_ff <= mul30(sn[0], cs[1]);
      cpcy_ff <= mul30(cs[0], cs[1]);
      cr_ff   <= cs[2];
      sr_ff   <= sn[2];
   end

   // ---------------- matrix stage B: three-factor terms, Q2.28 ----------------
   logic signed [TW-1:0] m_in [3][3];
   logic signed [TW-1:0] m_ff [3][3];
   always_comb begin
      m_in[0][0] = cycr_ff;
      m_in[0][1] = mul30(spsy_ff, cr_ff) - cpsr_ff;
      m_in[0][2] = mul30(cpsy_ff, cr_ff) + spsr_ff;
      m_in[1][0] = cysr_ff;
      m_in[1][1] = mul30(spsy_ff, sr_ff) + cpcr_ff;
      m_in[1][2] = mul30(cpsy_ff, sr_ff) - spcr_ff;
      m_in[2][0] = nsy_ff;
      m_in[2][1] = spcy_ff;
      m_in[2][2] = cpcy_ff;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m_in[i][j] = (m_in[i][j] + TW'(2)) >>> 2;
   end
   always_ff @(posedge clock) begin
      m_ff <= m_in;
   end

   // ---------------- rotate: products, sum, round, saturate ----------------
   logic signed [PW-1:0] pr_ff [3][3];
   logic signed [AccW-1:0] acc_ff [3];
   logic signed [AccW:0]   v_in [3];
   coord_type out_ff [3];
   logic      sat_ff;
   logic      sat_in;
   coord_type o_in [3];
   localparam logic signed [AccW:0] HI = (AccW+1)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [AccW:0] LO = -HI - (AccW+1)'(1);

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++)
            pr_ff[i][j] <= PW'(m_ff[i][j]) * PW'(d_ff[DLY-1][j]);
         acc_ff[i] <= AccW'(pr_ff[i][0]) + AccW'(pr_ff[i][1]) + AccW'(pr_ff[i][2]);
      end
   end

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         v_in[i] = (AccW+1)'(q_ff[DLY+1][i])
                 + (AccW+1)'((acc_ff[i] + (AccW'(1) <<< 27)) >>> 28);
         if (v_in[i] > HI) begin
            o_in[i] = coord_type'(HI);
            sat_in  = 1'b1;
         end else if (v_in[i] < LO) begin
            o_in[i] = coord_type'(LO);
            sat_in  = 1'b1;
         end else begin
            o_in[i] = coord_type'(v_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= o_in;
      sat_ff <= sat_in;
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_rotated_x = out_ff[0];
   assign rsp_rotated_y = out_ff[1];
   assign rsp_rotated_z = out_ff[2];
   assign rsp_saturated = sat_ff;
endmodule
`default_nettype wire

FILE: rtl/erp_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erp_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates three angle lanes by a fixed step index and registers them.
// ----------------------------------------------------------------------------
module erp_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic                  clock,
   input  wire erp_pkg::cordic_type   lane_in [3],
   output erp_pkg::cordic_type        lane_out [3]
);
   localparam logic [erp_pkg::STEP_WIDTH-1:0] IDX = erp_pkg::STEP_WIDTH'(STEP);
   localparam erp_pkg::trig_type ATAN = erp_pkg::atan_lookup(IDX);

   erp_pkg::cordic_type lane_ff [3];
   erp_pkg::cordic_type lane_rot_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (!lane_in[k].z[erp_pkg::TRIG_WIDTH-1]) begin
            lane_rot_in[k].x = lane_in[k].x - (lane_in[k].y >>> STEP);
            lane_rot_in[k].y = lane_in[k].y + (lane_in[k].x >>> STEP);
            lane_rot_in[k].z = lane_in[k].z - ATAN;
         end else begin
            lane_rot_in[k].x = lane_in[k].x + (lane_in[k].y >>> STEP);
            lane_rot_in[k].y = lane_in[k].y - (lane_in[k].x >>> STEP);
            lane_rot_in[k].z = lane_in[k].z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_rot_in;
   end

   assign lane_out = lane_ff;
endmodule
`default_nettype wire
